// ===== design/priority_wait_queue_defines.svh =====
// Assertion macros shared by the priority wait queue RTL.
// Depends on clk_i and rst_ni being in scope where the macros are used.
`ifndef PRIORITY_WAIT_QUEUE_DEFINES_SVH
`define PRIORITY_WAIT_QUEUE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define PWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PWQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== design/pwq_pkg.sv =====
// Package for the priority wait queue: field widths, status codes, entry type
// and the command/status structs between controller and datapath. No dependencies.
package pwq_pkg;

  localparam int unsigned QueueDepth = 16;

  localparam int unsigned TimeW     = 64;
  localparam int unsigned TieW      = 32;
  localparam int unsigned HandleW   = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 5;

  typedef enum logic [StatusW-1:0] {
    StatusDone  = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0]   prio_time;
    logic [TieW-1:0]    tie;
    logic [HandleW-1:0] handle;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;     // capture the accepted item
    logic init;      // clear walk state and result fields
    logic rd_head;   // read the head entry
    logic set_full;  // result: insert refused
    logic set_empty; // result: remove on empty queue
    logic step;      // one walk step over a stored entry
    logic tail;      // write the last entry of an insert
    logic pop;       // take the head entry out
    logic load_out;  // move the result into the output register
  } pwq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic last;
  } pwq_stat_t;

endpackage

// ===== design/pwq_if.sv =====
// Valid/ready channel interfaces for the priority wait queue items.
// Depends on pwq_pkg.
interface pwq_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [pwq_pkg::TimeW-1:0]    priority_time;
  logic [pwq_pkg::TieW-1:0]     tie_value;
  logic [pwq_pkg::HandleW-1:0]  task_handle;

  modport source (output valid, command, priority_time, tie_value, task_handle,
                  input ready);
  modport sink   (input valid, command, priority_time, tie_value, task_handle,
                  output ready);
endinterface

interface pwq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pwq_pkg::StatusW-1:0]    status;
  logic [pwq_pkg::CountOutW-1:0]  passed_count;
  logic [pwq_pkg::HandleW-1:0]    removed_task;
  logic [pwq_pkg::CountOutW-1:0]  queue_count;

  modport source (output valid, status, passed_count, removed_task, queue_count,
                  input ready);
  modport sink   (input valid, status, passed_count, removed_task, queue_count,
                  output ready);
endinterface

// ===== design/pwq_datapath.sv =====
// Datapath of the priority wait queue: entry memory as a circular buffer,
// insertion walk with carried entry, result and output registers. Depends on pwq_pkg.
module pwq_datapath #(
  parameter int unsigned QUEUE_DEPTH = pwq_pkg::QueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pwq_pkg::pwq_cmd_t               cmd_i,
  output pwq_pkg::pwq_stat_t              stat_o,
  input  logic                            command_i,
  input  logic [pwq_pkg::TimeW-1:0]       priority_time_i,
  input  logic [pwq_pkg::TieW-1:0]        tie_value_i,
  input  logic [pwq_pkg::HandleW-1:0]     task_handle_i,
  output logic [pwq_pkg::StatusW-1:0]     status_o,
  output logic [pwq_pkg::CountOutW-1:0]   passed_count_o,
  output logic [pwq_pkg::HandleW-1:0]     removed_task_o,
  output logic [pwq_pkg::CountOutW-1:0]   queue_count_o
);

  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  pwq_pkg::entry_t entry_mem [QUEUE_DEPTH];

  // Latched item
  logic                  cmd_q;
  pwq_pkg::entry_t       new_q;

  // Queue control
  logic [PtrW-1:0]       head_q, head_d;
  logic [CountW-1:0]     occ_q, occ_d;

  // Walk state
  logic [PtrW-1:0]       ptr_q, ptr_d;
  logic [CountW-1:0]     idx_q, idx_d;
  logic                  carrying_q, carrying_d;
  pwq_pkg::entry_t       carry_q, carry_d;
  pwq_pkg::entry_t       rdata_q;

  // Result fields
  pwq_pkg::status_e              status_q, status_d;
  logic [CountW-1:0]             passed_q, passed_d;
  logic [pwq_pkg::HandleW-1:0]   removed_q, removed_d;

  // Output register
  logic [pwq_pkg::StatusW-1:0]   out_status_q;
  logic [pwq_pkg::CountOutW-1:0] out_passed_q;
  logic [pwq_pkg::HandleW-1:0]   out_removed_q;
  logic [pwq_pkg::CountOutW-1:0] out_count_q;

  logic [PtrW-1:0]       ptr_inc, head_inc, rd_addr;
  logic                  rd_en, wr_en;
  pwq_pkg::entry_t       wdata;
  logic [pwq_pkg::TimeW-1:0] diff;
  logic                  precedes;

  // Wrapping pointer increments
  assign ptr_inc  = (ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign head_inc = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // New entry goes first: earlier wrapped time, or same time and smaller tie
  assign diff     = new_q.prio_time - rdata_q.prio_time;
  assign precedes = diff[pwq_pkg::TimeW-1] ||
                    ((new_q.prio_time == rdata_q.prio_time) && (new_q.tie < rdata_q.tie));

  // Status towards the controller
  assign stat_o.is_remove = cmd_q;
  assign stat_o.full      = (occ_q == CountW'(QUEUE_DEPTH));
  assign stat_o.empty     = (occ_q == '0);
  assign stat_o.last      = (CountW'(idx_q + 1'b1) == occ_q);

  // Memory port selection
  assign rd_en   = cmd_i.rd_head || cmd_i.step;
  assign rd_addr = cmd_i.step ? ptr_inc : head_q;
  assign wr_en   = cmd_i.tail || (cmd_i.step && (carrying_q || precedes));
  assign wdata   = carrying_q ? carry_q : new_q;

  // Walk, queue and result updates
  always_comb begin
    head_d     = head_q;
    occ_d      = occ_q;
    ptr_d      = ptr_q;
    idx_d      = idx_q;
    carrying_d = carrying_q;
    carry_d    = carry_q;
    status_d   = status_q;
    passed_d   = passed_q;
    removed_d  = removed_q;
    if (cmd_i.init) begin
      ptr_d      = head_q;
      idx_d      = '0;
      carrying_d = 1'b0;
      status_d   = pwq_pkg::StatusDone;
      passed_d   = '0;
      removed_d  = '0;
    end
    if (cmd_i.set_full) begin
      status_d = pwq_pkg::StatusFull;
    end
    if (cmd_i.set_empty) begin
      status_d = pwq_pkg::StatusEmpty;
    end
    if (cmd_i.step) begin
      if (carrying_q || precedes) begin
        carry_d    = rdata_q;
        carrying_d = 1'b1;
      end
      if (!carrying_q && precedes) begin
        passed_d = idx_q;
      end
      ptr_d = ptr_inc;
      idx_d = CountW'(idx_q + 1'b1);
    end
    if (cmd_i.tail) begin
      if (!carrying_q) begin
        passed_d = idx_q;
      end
      occ_d = CountW'(occ_q + 1'b1);
    end
    if (cmd_i.pop) begin
      removed_d = rdata_q.handle;
      head_d    = head_inc;
      occ_d     = CountW'(occ_q - 1'b1);
    end
  end

  // Queue control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      occ_q      <= '0;
      carrying_q <= 1'b0;
      status_q   <= pwq_pkg::StatusDone;
    end else begin
      head_q     <= head_d;
      occ_q      <= occ_d;
      carrying_q <= carrying_d;
      status_q   <= status_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q           <= command_i;
      new_q.prio_time <= priority_time_i;
      new_q.tie       <= tie_value_i;
      new_q.handle    <= task_handle_i;
    end
    ptr_q     <= ptr_d;
    idx_q     <= idx_d;
    carry_q   <= carry_d;
    passed_q  <= passed_d;
    removed_q <= removed_d;
    if (cmd_i.load_out) begin
      out_status_q  <= status_q;
      out_passed_q  <= pwq_pkg::CountOutW'(passed_q);
      out_removed_q <= removed_q;
      out_count_q   <= pwq_pkg::CountOutW'(occ_q);
    end
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[ptr_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= entry_mem[rd_addr];
    end
  end

  assign status_o       = out_status_q;
  assign passed_count_o = out_passed_q;
  assign removed_task_o = out_removed_q;
  assign queue_count_o  = out_count_q;

endmodule

// ===== design/pwq_ctrl.sv =====
// Controller of the priority wait queue: sequences accept, walk, write-back,
// pop and result hand-off. Depends on pwq_pkg and priority_wait_queue_defines.svh.
`include "priority_wait_queue_defines.svh"

module pwq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pwq_pkg::pwq_cmd_t  cmd_o,
  input  pwq_pkg::pwq_stat_t stat_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StWalk  = 3'd2;
  localparam logic [2:0] StTail  = 3'd3;
  localparam logic [2:0] StPop   = 3'd4;
  localparam logic [2:0] StReply = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.latch = accept;
        if (accept) begin
          state_d = StStart;
        end
      end
      StStart: begin
        cmd_o.init = 1'b1;
        if (stat_i.is_remove) begin
          if (stat_i.empty) begin
            cmd_o.set_empty = 1'b1;
            state_d         = StReply;
          end else begin
            cmd_o.rd_head = 1'b1;
            state_d       = StPop;
          end
        end else if (stat_i.full) begin
          cmd_o.set_full = 1'b1;
          state_d        = StReply;
        end else if (stat_i.empty) begin
          state_d = StTail;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = StWalk;
        end
      end
      StWalk: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = StTail;
        end
      end
      StTail: begin
        cmd_o.tail = 1'b1;
        state_d    = StReply;
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d   = StReply;
      end
      StReply: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PWQ_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == StStart, "accepted item did not start")
  `PWQ_ASSERT(a_result_from_reply, $rose(out_valid_q) |-> ($past(state_q) == StReply), "result raised outside reply")
  `PWQ_ASSERT(a_walk_needs_entries, (state_q == StWalk) |-> !stat_i.empty, "walk over an empty queue")

endmodule

// ===== design/priority_wait_queue.sv =====
// Priority wait queue: insert, remove and a registered result per item.
// From accept, a remove passes start, pop and reply; a refused item start and reply; an insert
// start, one walk step per stored entry, tail and reply. Reply waits until the output is free.
// The next item is accepted in the cycle after the result is loaded, not before.
// The walk over the entry memory, one entry per cycle, sets the insert time.
// Reset clears occupancy, head pointer and control state; entry memory is not cleared.
module priority_wait_queue #(
  parameter int unsigned QUEUE_DEPTH = pwq_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pwq_req_if.sink          req_i,
  pwq_rsp_if.source        rsp_o
);

  pwq_pkg::pwq_cmd_t  cmd;
  pwq_pkg::pwq_stat_t stat;

  // Sequencing
  pwq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Storage and compare
  pwq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (req_i.command),
    .priority_time_i (req_i.priority_time),
    .tie_value_i     (req_i.tie_value),
    .task_handle_i   (req_i.task_handle),
    .status_o        (rsp_o.status),
    .passed_count_o  (rsp_o.passed_count),
    .removed_task_o  (rsp_o.removed_task),
    .queue_count_o   (rsp_o.queue_count)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for priority_wait_queue: directed and random insert/remove items,
// checked against a sorted-queue predictor held in a small scoreboard class.
// Depends on pwq_pkg, pwq_req_if/pwq_rsp_if and the priority_wait_queue RTL.
module tb_top;

  localparam int unsigned DirectedInserts = 16;
  localparam int unsigned DirectedRemoves = 7;
  localparam int unsigned RandomItems     = 1425;
  localparam int unsigned QuietTailItems  = 150;
  localparam int unsigned HoldItemIndex   = 100;
  localparam int unsigned HoldCycles      = 300;
  localparam int unsigned StallLimit      = 2000;
  localparam int unsigned DrainCycles     = 30;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  localparam logic [pwq_pkg::TimeW-1:0] TimeZero    = 64'h0000_0000_0000_0000;
  localparam logic [pwq_pkg::TimeW-1:0] TimeMax     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [pwq_pkg::TimeW-1:0] TimeHalf    = 64'h8000_0000_0000_0000;
  localparam logic [pwq_pkg::TimeW-1:0] TimeHalfLow = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    pwq_pkg::status_e              status;
    logic [pwq_pkg::CountOutW-1:0] passed;
    logic [pwq_pkg::HandleW-1:0]   removed;
    logic [pwq_pkg::CountOutW-1:0] count;
  } wait_result_t;

  // Sorted copy of the wait queue and the results still owed by the block
  class pwq_scoreboard;
    pwq_pkg::entry_t waiting_q[$];
    wait_result_t    expected_q[$];
    int unsigned     fails;

    function new();
      fails = 0;
    endfunction

    // Earlier time under wrap-around difference, or same time and smaller tie
    function bit precedes(pwq_pkg::entry_t a, pwq_pkg::entry_t b);
      logic [pwq_pkg::TimeW-1:0] diff;
      diff = a.prio_time - b.prio_time;
      return diff[pwq_pkg::TimeW-1] || (a.prio_time == b.prio_time && a.tie < b.tie);
    endfunction

    function void note_item(bit is_remove, pwq_pkg::entry_t item);
      wait_result_t r;
      int unsigned  pos;
      r.status  = pwq_pkg::StatusDone;
      r.passed  = '0;
      r.removed = '0;
      pos       = 0;
      if (!is_remove) begin
        if (waiting_q.size() >= pwq_pkg::QueueDepth) begin
          r.status = pwq_pkg::StatusFull;
        end else begin
          // stop at the first entry from the head that the new one precedes
          while (pos < waiting_q.size() && !precedes(item, waiting_q[pos])) pos++;
          waiting_q.insert(pos, item);
          r.passed = pos[pwq_pkg::CountOutW-1:0];
        end
      end else if (waiting_q.size() == 0) begin
        r.status = pwq_pkg::StatusEmpty;
      end else begin
        r.removed = waiting_q[0].handle;
        void'(waiting_q.pop_front());
      end
      r.count = pwq_pkg::CountOutW'(waiting_q.size());
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [pwq_pkg::StatusW-1:0]   status,
                               logic [pwq_pkg::CountOutW-1:0] passed,
                               logic [pwq_pkg::HandleW-1:0]   removed,
                               logic [pwq_pkg::CountOutW-1:0] count);
      wait_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: status %0d queue_count %0d", status, count);
        fails++;
        return;
      end
      r = expected_q.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        fails++;
      end
      if (passed !== r.passed) begin
        $error("passed_count: expected %0d, got %0d", r.passed, passed);
        fails++;
      end
      if (removed !== r.removed) begin
        $error("removed_task: expected 0x%04h, got 0x%04h", r.removed, removed);
        fails++;
      end
      if (count !== r.count) begin
        $error("queue_count: expected %0d, got %0d", r.count, count);
        fails++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet_tail;
  bit   hold_rsp_req;
  bit   hold_rsp_done;
  int unsigned quiet_cycles;

  pwq_scoreboard board;

  pwq_req_if req_bus ();
  pwq_rsp_if rsp_bus ();

  priority_wait_queue uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Keys for the directed part: extremes, equal keys and wrap-around cases
  logic [pwq_pkg::TimeW-1:0] dir_time [DirectedInserts] = '{
    TimeZero, TimeZero, TimeZero, TimeZero, TimeMax, TimeHalf, TimeHalfLow,
    64'h4000_0000_0000_0000, 64'h0000_0000_0000_0001, TimeMax, 64'h0000_0000_0000_0005,
    64'h0000_0000_0000_0005, 64'h8000_0000_0000_0001, 64'h1234_5678_9ABC_DEF0,
    64'hFFFF_FFFF_FFFF_FFFE, TimeHalf
  };
  logic [pwq_pkg::TieW-1:0] dir_tie [DirectedInserts] = '{
    32'd5, 32'd5, 32'd0, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'hFFFF_FFFF, 32'd1,
    32'd2, 32'd6, 32'hFFFF_FFFF, 32'h0000_0000, 32'd3, 32'h8000_0000, 32'd9, 32'd0
  };
  logic [pwq_pkg::HandleW-1:0] dir_handle [DirectedInserts] = '{
    16'h0001, 16'h0002, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
    16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h0060, 16'h0070, 16'h0080
  };

  // Clock: 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one item and hold it until the block takes it
  task automatic send_item(input logic cmd, input logic [pwq_pkg::TimeW-1:0] t,
                           input logic [pwq_pkg::TieW-1:0] k,
                           input logic [pwq_pkg::HandleW-1:0] h);
    pwq_pkg::entry_t item;
    @(negedge clk);
    req_bus.valid         <= 1'b1;
    req_bus.command       <= cmd;
    req_bus.priority_time <= t;
    req_bus.tie_value     <= k;
    req_bus.task_handle   <= h;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    item.prio_time = t;
    item.tie       = k;
    item.handle    = h;
    board.note_item(cmd == CmdRemove, item);
  endtask

  // Drop valid for a number of cycles
  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk);
    req_bus.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Times clustered round a base, near the wrap point, at the extremes or anywhere
  function automatic logic [pwq_pkg::TimeW-1:0] pick_time(
      input logic [pwq_pkg::TimeW-1:0] base);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return base + pwq_pkg::TimeW'($urandom_range(0, 7));
    if (sel < 60) return base + TimeHalf - pwq_pkg::TimeW'($urandom_range(0, 3));
    if (sel < 75) begin
      case ($urandom_range(0, 3))
        0: return TimeZero;
        1: return TimeMax;
        2: return TimeHalf;
        default: return TimeHalfLow;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [pwq_pkg::TieW-1:0] pick_tie();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return pwq_pkg::TieW'($urandom_range(0, 3));
    if (sel < 9) return $urandom;
    return ($urandom_range(0, 1) == 0) ? '0 : '1;
  endfunction

  // Stimulus, drain and verdict
  initial begin : req_driver
    logic [pwq_pkg::TimeW-1:0] base_time;
    int unsigned               insert_pct;
    int unsigned               idle_pct;
    logic                      cmd;
    req_bus.valid         = 1'b0;
    req_bus.command       = CmdInsert;
    req_bus.priority_time = '0;
    req_bus.tie_value     = '0;
    req_bus.task_handle   = '0;
    rst_n                 = 1'b0;
    quiet_tail            = 1'b0;
    hold_rsp_req          = 1'b0;
    base_time             = '0;
    insert_pct            = 50;
    idle_pct              = 0;
    board                 = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: remove on empty, fill with edge keys, insert on full, partial drain
    send_item(CmdRemove, TimeMax, '1, '1);
    for (int i = 0; i < DirectedInserts; i++) begin
      send_item(CmdInsert, dir_time[i], dir_tie[i], dir_handle[i]);
    end
    send_item(CmdInsert, TimeZero, '0, 16'hFFFF);
    for (int i = 0; i < DirectedRemoves; i++) begin
      send_item(CmdRemove, '0, '0, '0);
    end

    // Random: segments that fill, drain or hover, with clustered keys
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 80;
          1: insert_pct = 20;
          2: insert_pct = 50;
          default: insert_pct = 60;
        endcase
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 30;
        endcase
        base_time = {$urandom, $urandom};
      end
      if (i == HoldItemIndex) hold_rsp_req = 1'b1;
      if (i >= RandomItems - QuietTailItems) quiet_tail = 1'b1;
      cmd = ($urandom_range(0, 99) < insert_pct) ? CmdInsert : CmdRemove;
      send_item(cmd, pick_time(base_time), pick_tie(), pwq_pkg::HandleW'($urandom));
      if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        idle_sender($urandom_range(1, 13));
      end
    end
    @(negedge clk);
    req_bus.valid <= 1'b0;

    // Wait for every owed result, then let the block settle
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold-off, always ready at the end
  initial begin : rsp_driver
    int unsigned stall_pct;
    int unsigned cycle_no;
    rsp_bus.ready = 1'b0;
    hold_rsp_done = 1'b0;
    stall_pct     = 0;
    cycle_no      = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cycle_no++;
      if (cycle_no % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (hold_rsp_req && !hold_rsp_done) begin
        hold_rsp_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      board.check_result(rsp_bus.status, rsp_bus.passed_count, rsp_bus.removed_task,
                         rsp_bus.queue_count);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                 (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pwq_pkg.sv
design/pwq_if.sv
design/pwq_datapath.sv
design/pwq_ctrl.sv
design/priority_wait_queue.sv
tb/tb_top.sv
